// File: design/msl_pkg.sv
// Shared types and constants of the margin softmax loss gradient unit.
package msl_pkg;

  localparam int IDX_W = 6;
  localparam int DIM_W = 7;

  localparam logic signed [16:0] MINUS_ONE_Q15 = -17'sd32768;
  localparam logic [15:0] LN2_Q16 = 16'd45426;

  localparam logic [2:0] REG_ROW_LENGTH     = 3'd0;
  localparam logic [2:0] REG_MARGIN         = 3'd1;
  localparam logic [2:0] REG_PENALTY_WEIGHT = 3'd2;
  localparam logic [2:0] REG_OFFSET_GAMMA   = 3'd3;
  localparam logic [2:0] REG_GRAD_SCALE     = 3'd4;

  typedef struct packed {
    logic [DIM_W-1:0]  dim;
    logic [3:0]        label;
    logic              lab_in;
    logic [15:0]       g;
    logic [15:0]       e;
    logic signed [16:0] rival_p;
    logic [IDX_W-1:0]  rival_i;
  } row_desc_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [IDX_W-1:0] addr;
    logic [15:0]      data;
  } store_wr_t;

endpackage

// File: design/msl_front.sv
// Row loader: writes probabilities, tracks label, extra and best rival, emits a row descriptor.
module msl_front #(
  parameter int MAX_ROW_LENGTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [15:0]         probability,
  input  logic [3:0]          label_index,
  input  logic                row_end,
  input  logic [4:0]          row_length,
  input  logic                q_full,
  input  logic                bank,
  output msl_pkg::store_wr_t  st_wr,
  output logic                desc_push,
  output msl_pkg::row_desc_t  desc
);
  import msl_pkg::*;

  logic [DIM_W-1:0]  cnt;
  logic [3:0]        lbl;
  logic [15:0]       g_val;
  logic [15:0]       prev_p;
  logic signed [16:0] rival_p;
  logic [IDX_W-1:0]  rival_i;

  logic              accept, first, hit, upd, close;
  logic [3:0]        lab_cur;
  logic [IDX_W-1:0]  idx, prev_i, riv_i_cur, riv_i_new;
  logic signed [16:0] riv_p_cur, riv_p_new;
  logic [15:0]       g_new;
  logic [DIM_W-1:0]  rl, dim;

  always_comb begin
    accept    = push && !q_full;
    first     = (cnt == '0);
    lab_cur   = first ? label_index : lbl;
    idx       = cnt[IDX_W-1:0];
    prev_i    = idx - IDX_W'(1);
    hit       = (idx == IDX_W'(lab_cur));
    riv_p_cur = first ? MINUS_ONE_Q15 : rival_p;
    riv_i_cur = first ? '0 : rival_i;
    upd = !first && (prev_i != IDX_W'(lab_cur)) && ($signed({1'b0, prev_p}) > riv_p_cur);
    riv_p_new = upd ? $signed({1'b0, prev_p}) : riv_p_cur;
    riv_i_new = upd ? prev_i : riv_i_cur;
    g_new     = hit ? probability : (first ? 16'd0 : g_val);
    if (DIM_W'(row_length) < DIM_W'(3)) begin
      rl = DIM_W'(3);
    end else if (DIM_W'(row_length) > DIM_W'(MAX_ROW_LENGTH)) begin
      rl = DIM_W'(MAX_ROW_LENGTH);
    end else begin
      rl = DIM_W'(row_length);
    end
    dim   = cnt + DIM_W'(1);
    close = row_end || (dim >= rl);

    st_wr.en   = accept;
    st_wr.bank = bank;
    st_wr.addr = idx;
    st_wr.data = probability;

    desc_push    = accept && close;
    desc.dim     = dim;
    desc.label   = lab_cur;
    desc.lab_in  = (DIM_W'(lab_cur) < dim);
    desc.g       = g_new;
    desc.e       = probability;
    desc.rival_p = riv_p_new;
    desc.rival_i = riv_i_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= close ? '0 : dim;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lbl     <= lab_cur;
      g_val   <= g_new;
      prev_p  <= probability;
      rival_p <= riv_p_new;
      rival_i <= riv_i_new;
    end
  end

endmodule

// File: design/msl_queue.sv
// Two-entry row descriptor queue; its pointers also pick the probability store bank.
module msl_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  msl_pkg::row_desc_t din,
  input  logic               pop,
  output msl_pkg::row_desc_t dout,
  output logic               valid,
  output logic               full,
  output logic               wr_ptr,
  output logic               rd_ptr
);
  import msl_pkg::*;

  row_desc_t  slot [0:1];
  logic [1:0] count;

  assign valid = (count != 2'd0);
  assign full  = (count == 2'd2);
  assign dout  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= din;
  end

endmodule

// File: design/msl_back.sv
// Row engine: loss (log sequencer), quotients (serial divider), per-class gradients.
module msl_back #(
  parameter int MAX_ROW_LENGTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  msl_pkg::store_wr_t  st_wr,
  input  logic                q_valid,
  input  msl_pkg::row_desc_t  desc,
  input  logic                rd_bank,
  output logic                q_pop,
  input  logic signed [16:0]  margin,
  input  logic [19:0]         penalty_weight,
  input  logic [15:0]         offset_gamma,
  input  logic [15:0]         grad_scale,
  input  logic                pop,
  output logic                empty,
  output logic signed [23:0]  gradient,
  output logic [3:0]          class_index,
  output logic signed [23:0]  sample_loss,
  output logic [3:0]          rival_index,
  output logic                last_result
);
  import msl_pkg::*;

  localparam int IW = $clog2(MAX_ROW_LENGTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NORM = 4'd1;
  localparam logic [3:0] S_SQ   = 4'd2;
  localparam logic [3:0] S_LOGM = 4'd3;
  localparam logic [3:0] S_LOGR = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_RD   = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_ADD  = 4'd8;
  localparam logic [3:0] S_LAM  = 4'd9;
  localparam logic [3:0] S_ACC  = 4'd10;
  localparam logic [3:0] S_SCL  = 4'd11;
  localparam logic [3:0] S_OUT  = 4'd12;

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    if (v > 48'sd8388607) return 24'sd8388607;
    if (v < -48'sd8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

  logic [15:0] store [0:1][0:MAX_ROW_LENGTH-1];
  logic [15:0] rdata;

  logic [3:0]         st;
  logic [IW-1:0]      j;
  row_desc_t          dsc;
  logic [17:0]        den;
  logic signed [18:0] dd;
  logic signed [17:0] diff;
  logic [30:0]        nm, m;
  logic [4:0]         ex;
  logic [15:0]        frac;
  logic [3:0]         it;
  logic signed [39:0] pen_prod;
  logic signed [24:0] pen;
  logic signed [38:0] lnp;
  logic signed [23:0] loss;
  logic [31:0]        dv_n;
  logic [17:0]        dv_r;
  logic [16:0]        dv_q;
  logic [4:0]         dc;
  logic               dsel;
  logic [16:0]        qg, qe;
  logic [15:0]        pj;
  logic signed [34:0] prod;
  logic signed [35:0] xv;
  logic [16:0]        sub;
  logic               k_lab, k_ext, k_riv;
  logic [36:0]        pl;
  logic signed [39:0] ph;
  logic signed [27:0] acc;
  logic signed [44:0] sc;
  logic               ov;

  logic               pen_on, has_rival, is_last, wr_out;
  logic [17:0]        den_in, lsafe;
  logic [61:0]        sq;
  logic signed [21:0] v;
  logic signed [38:0] lnq;
  logic signed [24:0] pen_r;
  logic [18:0]        dv_t;
  logic               dv_b;
  logic [16:0]        dv_fin;
  logic signed [56:0] lsum;
  logic signed [56:0] term;
  logic signed [44:0] gv;

  always_comb begin
    pen_on    = (dd > 19'sd0);
    has_rival = !dsc.rival_p[16];
    is_last   = (DIM_W'(j) == DIM_W'(dsc.dim - DIM_W'(1)));
    wr_out    = (st == S_OUT) && (!ov || pop);
    q_pop     = wr_out && is_last;
    empty     = !ov;
    den_in    = 18'(desc.g) + 18'(desc.e) + 18'(offset_gamma);
    lsafe     = (den_in == 18'd0) ? 18'd1 : den_in;
    sq        = 62'(m) * 62'(m);
    v         = $signed(22'(15 << 16)) - $signed({1'b0, ex, frac});
    lnq       = (lnp + 39'sd65536) >>> 17;
    pen_r     = 25'((pen_prod + 40'sd16384) >>> 15);
    dv_t      = {dv_r, dv_n[31]};
    dv_b      = (dv_t >= 19'(den));
    dv_fin    = (den == 18'd0) ? 17'd0 : {dv_q[15:0], dv_b};
    lsum      = $signed({ph, 17'b0}) + $signed({20'b0, pl});
    term      = (lsum + 57'sd536870912) >>> 30;
    gv        = (sc + 45'sd16384) >>> 15;
  end

  always_ff @(posedge clk) begin
    if (st_wr.en) store[st_wr.bank][st_wr.addr[IW-1:0]] <= st_wr.data;
    rdata <= store[rd_bank][j];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      ov <= 1'b0;
    end else begin
      if (wr_out) begin
        ov <= 1'b1;
      end else if (pop && ov) begin
        ov <= 1'b0;
      end
      unique case (st)
        S_IDLE: if (q_valid) st <= S_NORM;
        S_NORM: if (nm[30]) st <= S_SQ;
        S_SQ:   if (it == 4'd15) st <= S_LOGM;
        S_LOGM: st <= S_LOGR;
        S_LOGR: st <= S_DIV;
        S_DIV:  if (dc == 5'd31 && dsel) st <= S_RD;
        S_RD:   st <= S_MUL;
        S_MUL:  st <= S_ADD;
        S_ADD:  st <= S_LAM;
        S_LAM:  st <= S_ACC;
        S_ACC:  st <= S_SCL;
        S_SCL:  st <= S_OUT;
        S_OUT:  if (wr_out) st <= is_last ? S_IDLE : S_RD;
        default: st <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st)
      S_IDLE: begin
        dsc  <= desc;
        den  <= den_in;
        dd   <= 19'($signed(desc.rival_p)) + 19'(margin) - $signed({3'b0, desc.g});
        diff <= $signed({2'b0, desc.g}) - 18'($signed(desc.rival_p));
        nm   <= 31'(lsafe);
        ex   <= 5'd30;
      end
      S_NORM: begin
        pen_prod <= $signed({1'b0, penalty_weight}) * dd;
        if (nm[30]) begin
          m    <= nm;
          it   <= 4'd0;
          frac <= 16'd0;
        end else begin
          nm <= {nm[29:0], 1'b0};
          ex <= ex - 5'd1;
        end
      end
      S_SQ: begin
        if (sq[61]) begin
          m    <= sq[61:31];
          frac <= {frac[14:0], 1'b1};
        end else begin
          m    <= sq[60:30];
          frac <= {frac[14:0], 1'b0};
        end
        it <= it + 4'd1;
      end
      S_LOGM: begin
        lnp <= v * $signed({1'b0, LN2_Q16});
        pen <= pen_on ? pen_r : 25'sd0;
      end
      S_LOGR: begin
        loss <= sat24(48'(lnq) + 48'(pen));
        dv_n <= 32'({dsc.g, 15'b0}) + 32'(den[17:1]);
        dv_r <= 18'd0;
        dv_q <= 17'd0;
        dc   <= 5'd0;
        dsel <= 1'b0;
      end
      S_DIV: begin
        dc <= dc + 5'd1;
        if (dc == 5'd31 && !dsel) begin
          // label quotient done, start the extra-class quotient
          qg   <= dv_fin;
          dv_n <= 32'({dsc.e, 15'b0}) + 32'(den[17:1]);
          dv_r <= 18'd0;
          dv_q <= 17'd0;
          dsel <= 1'b1;
        end else begin
          dv_r <= dv_b ? 18'(dv_t - 19'(den)) : dv_t[17:0];
          dv_q <= {dv_q[15:0], dv_b};
          dv_n <= {dv_n[30:0], 1'b0};
          if (dc == 5'd31) begin
            qe <= dv_fin;
            j  <= '0;
          end
        end
      end
      S_MUL: begin
        pj    <= rdata;
        prod  <= $signed({1'b0, rdata}) * diff;
        k_lab <= dsc.lab_in && (IDX_W'(j) == IDX_W'(dsc.label));
        k_ext <= is_last;
        k_riv <= has_rival && (IDX_W'(j) == dsc.rival_i);
      end
      S_ADD: begin
        priority if (k_lab) begin
          xv  <= 36'(prod) - $signed({5'b0, pj, 15'b0});
          sub <= qg;
        end else if (k_ext) begin
          xv  <= 36'(prod);
          sub <= qe;
        end else if (k_riv) begin
          xv  <= 36'(prod) + $signed({5'b0, pj, 15'b0});
          sub <= 17'd0;
        end else begin
          xv  <= 36'(prod);
          sub <= 17'd0;
        end
      end
      S_LAM: begin
        pl <= 37'(penalty_weight) * 37'(xv[16:0]);
        ph <= $signed({1'b0, penalty_weight}) * $signed(xv[35:17]);
      end
      S_ACC: begin
        acc <= $signed({12'b0, pj}) - $signed({11'b0, sub})
               + (pen_on ? 28'(term) : 28'sd0);
      end
      S_SCL: begin
        sc <= acc * $signed({1'b0, grad_scale});
      end
      S_OUT: begin
        if (wr_out) begin
          gradient    <= sat24(48'(gv));
          class_index <= 4'(j);
          sample_loss <= loss;
          rival_index <= has_rival ? 4'(dsc.rival_i) : 4'd0;
          last_result <= is_last;
          if (!is_last) j <= j + IW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: design/margin_softmax_loss_gradient_unit.sv
// Top level of the margin softmax loss gradient unit.
//
// Input channel (push/full): one probability per item, Q1.15, with the row's
// label on the first item and row_end on the last. A row also closes once
// row_length items have loaded (row_length clamped to 3..MAX_ROW_LENGTH).
// The loader takes one item per cycle while full is low, into one of two store banks.
// Result channel (empty/pop): one gradient item per class, in class order,
// each carrying the row's sample loss and rival index; last_result marks
// the extra class. A result holds on the ports until popped.
// Row processing: after a row closes, the row engine takes the row, then runs
// exponent normalization (shorter for larger denominators), the log squaring
// loop, the scaling and the two serial quotients, then per class the gradient
// datapath (store read, product, term select, lambda split product, sum,
// scale, output).
// The row engine finishes one row before it takes the next;
// a second row loads into the other bank while the first is being worked.
// full rises when both banks hold unfinished rows. A stalled receiver holds
// the row engine at its output step; nothing is dropped.
// Reset clears the row counter, queue and output valid, and restores the
// register defaults (row length 16, grad scale 1.0, others zero).
module margin_softmax_loss_gradient_unit #(
  parameter int MAX_ROW_LENGTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [15:0]        probability,
  input  logic [3:0]         label_index,
  input  logic               row_end,
  output logic               empty,
  input  logic               pop,
  output logic signed [23:0] gradient,
  output logic [3:0]         class_index,
  output logic signed [23:0] sample_loss,
  output logic [3:0]         rival_index,
  output logic               last_result,
  input  logic               write_enable,
  input  logic [2:0]         write_index,
  input  logic [19:0]        write_data
);
  import msl_pkg::*;

  // configuration registers
  logic [4:0]         row_length;
  logic signed [16:0] margin;
  logic [19:0]        penalty_weight;
  logic [15:0]        offset_gamma;
  logic [15:0]        grad_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length     <= 5'd16;
      margin         <= 17'sd0;
      penalty_weight <= 20'd0;
      offset_gamma   <= 16'd0;
      grad_scale     <= 16'd32768;
    end else if (write_enable) begin
      unique case (write_index)
        REG_ROW_LENGTH:     row_length     <= write_data[4:0];
        REG_MARGIN:         margin         <= $signed(write_data[16:0]);
        REG_PENALTY_WEIGHT: penalty_weight <= write_data;
        REG_OFFSET_GAMMA:   offset_gamma   <= write_data[15:0];
        REG_GRAD_SCALE:     grad_scale     <= write_data[15:0];
        default: begin
        end
      endcase
    end
  end

  store_wr_t st_wr;
  row_desc_t f_desc, q_desc;
  logic      f_push, q_valid, q_full, q_pop, wr_ptr, rd_ptr;

  assign full = q_full;

  // front: loader and rival tracker
  msl_front #(.MAX_ROW_LENGTH(MAX_ROW_LENGTH)) u_front (
    .clk(clk), .rst(rst), .push(push), .probability(probability),
    .label_index(label_index), .row_end(row_end), .row_length(row_length),
    .q_full(q_full), .bank(wr_ptr), .st_wr(st_wr), .desc_push(f_push),
    .desc(f_desc)
  );

  // row queue between loader and engine
  msl_queue u_queue (
    .clk(clk), .rst(rst), .push(f_push), .din(f_desc), .pop(q_pop),
    .dout(q_desc), .valid(q_valid), .full(q_full), .wr_ptr(wr_ptr),
    .rd_ptr(rd_ptr)
  );

  // back: loss and gradient engine with the output register
  msl_back #(.MAX_ROW_LENGTH(MAX_ROW_LENGTH)) u_back (
    .clk(clk), .rst(rst), .st_wr(st_wr), .q_valid(q_valid), .desc(q_desc),
    .rd_bank(rd_ptr), .q_pop(q_pop), .margin(margin),
    .penalty_weight(penalty_weight), .offset_gamma(offset_gamma),
    .grad_scale(grad_scale), .pop(pop), .empty(empty), .gradient(gradient),
    .class_index(class_index), .sample_loss(sample_loss),
    .rival_index(rival_index), .last_result(last_result)
  );

endmodule
